@@ rtl/qeg_pkg.sv @@
// Shared types and constants for the quadrature electronic gearbox.
// No dependencies; each rtl file but qeg_checker refers into it by scoped names.
`default_nettype none

package qeg_pkg;

  // Width of the position and step counters, two's complement.
  localparam int COUNT_WIDTH = 48;

  // Multiply works in 32-bit limbs of the position magnitude.
  localparam int NLIMB      = (COUNT_WIDTH + 31) / 32;
  localparam int MAG_W      = 32 * NLIMB;
  localparam int PROD_W     = MAG_W + 32;
  localparam int SEQ_CNT_W  = $clog2(PROD_W + 1);

  // Quotient limits for saturation of the target.
  localparam logic [PROD_W-1:0] LIMIT_NEG = PROD_W'(1) << (COUNT_WIDTH - 1);
  localparam logic [PROD_W-1:0] LIMIT_POS = LIMIT_NEG - PROD_W'(1);

  // Input kind codes.
  localparam logic [1:0] KIND_EDGE   = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_THREAD_PITCH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEPS_REV    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIV_REV      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREW_PITCH  = 3'd4;

  // Command queue depth (power of two).
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  typedef struct packed {
    logic [15:0] thread_pitch_milli;
    logic        reverse_thread;
    logic [15:0] steps_per_rev;
    logic [15:0] divisions_per_rev;
    logic [15:0] screw_pitch_milli;
  } cfg_t;

  // Classified work for the back end.
  typedef enum logic [1:0] {
    CMD_UP,
    CMD_DOWN,
    CMD_UPDATE,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_SAT,
    ST_DIFF,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/qeg_front.sv @@
// Front end: accepts input items and classifies them into back-end commands.
// Depends on qeg_pkg.
`default_nettype none

module qeg_front (
  input  wire logic               in_push,
  input  wire logic [1:0]         in_kind,
  input  wire logic               in_channel,
  input  wire logic               in_rising,
  input  wire logic               in_other_level,
  output logic                    in_full,
  input  wire qeg_pkg::q_status_t q_status,
  output logic                    q_push,
  output qeg_pkg::cmd_t           q_cmd
);

  logic queue_it;

  always_comb begin
    queue_it = 1'b1;
    q_cmd    = qeg_pkg::CMD_UP;
    unique case (in_kind)
      qeg_pkg::KIND_EDGE: begin
        // count up when channel ^ rising ^ other is low
        q_cmd = (in_channel ^ in_rising ^ in_other_level) ? qeg_pkg::CMD_DOWN
                                                           : qeg_pkg::CMD_UP;
      end
      qeg_pkg::KIND_UPDATE: q_cmd = qeg_pkg::CMD_UPDATE;
      qeg_pkg::KIND_CLEAR:  q_cmd = qeg_pkg::CMD_CLEAR;
      default:              queue_it = 1'b0;  // unused kind: dropped
    endcase
  end

  assign in_full = q_status.full;
  assign q_push  = in_push && !q_status.full && queue_it;

endmodule

`default_nettype wire

@@ rtl/qeg_cmd_fifo.sv @@
// Short command queue between the front and back ends.
// Depends on qeg_pkg.
`default_nettype none

module qeg_cmd_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire qeg_pkg::cmd_t      push_cmd,
  input  wire logic               pop,
  output qeg_pkg::cmd_t           head_cmd,
  output qeg_pkg::q_status_t      status
);

  qeg_pkg::cmd_t                  mem_r [qeg_pkg::CMD_DEPTH];
  logic [qeg_pkg::CMD_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [qeg_pkg::CMD_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [qeg_pkg::CMD_PTR_W:0]    count_r, count_nxt;
  logic                           do_push, do_pop;

  assign status.full  = (count_r == (qeg_pkg::CMD_PTR_W+1)'(qeg_pkg::CMD_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/qeg_back.sv @@
// Back end: position and step counters, limb multiplier, bit-serial divider,
// saturation and the result register. Depends on qeg_pkg.
`default_nettype none

module qeg_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire qeg_pkg::cfg_t      cfg,
  input  wire qeg_pkg::cmd_t      q_cmd,
  input  wire qeg_pkg::q_status_t q_status,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [15:0]             out_step_count,
  output logic                    out_direction
);

  localparam int CW = qeg_pkg::COUNT_WIDTH;
  localparam int PW = qeg_pkg::PROD_W;
  localparam int MW = qeg_pkg::MAG_W;
  localparam int SW = qeg_pkg::SEQ_CNT_W;

  qeg_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic          neg_r, neg_nxt;
  logic [MW-1:0] mag_r, mag_nxt;
  logic [31:0]   num_r, num_nxt;
  logic [31:0]   den_r, den_nxt;
  logic [63:0]   pp_r, pp_nxt;
  logic [PW-1:0] prod_r, prod_nxt;     // product, then dividend/quotient
  logic [31:0]   rem_r, rem_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] target_r, target_nxt;
  logic [CW:0]   diff_r, diff_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_count_r, out_count_nxt;
  logic          out_dir_r, out_dir_nxt;

  logic [CW-1:0] pos_abs;
  logic [32:0]   trial;
  logic          trial_ge;
  logic [32:0]   trial_sub;
  logic [PW-1:0] limit;
  logic [PW-1:0] qmag;
  logic [CW:0]   diff_abs;
  logic          delta_pos, delta_neg;

  assign pos_abs   = pos_r[CW-1] ? (~pos_r + CW'(1)) : pos_r;
  assign trial     = {rem_r, prod_r[PW-1]};
  assign trial_ge  = (trial >= {1'b0, den_r});
  assign trial_sub = trial - {1'b0, den_r};
  assign limit     = neg_r ? qeg_pkg::LIMIT_NEG : qeg_pkg::LIMIT_POS;
  assign qmag      = (prod_r > limit) ? limit : prod_r;
  assign diff_abs  = diff_r[CW] ? (~diff_r + (CW+1)'(1)) : diff_r;
  assign delta_neg = diff_r[CW];
  assign delta_pos = !diff_r[CW] && (diff_r != '0);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    steps_nxt     = steps_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    pp_nxt        = pp_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    target_nxt    = target_r;
    diff_nxt      = diff_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_count_nxt = out_count_r;
    out_dir_nxt   = out_dir_r;
    q_pop         = 1'b0;

    unique case (state_r)
      qeg_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          q_pop = 1'b1;
          unique case (q_cmd)
            qeg_pkg::CMD_UP:   pos_nxt = pos_r + CW'(1);
            qeg_pkg::CMD_DOWN: pos_nxt = pos_r - CW'(1);
            qeg_pkg::CMD_CLEAR: begin
              pos_nxt   = '0;
              steps_nxt = '0;
            end
            qeg_pkg::CMD_UPDATE: begin
              if (pos_r == '0) begin
                target_nxt = steps_r;
                state_nxt  = qeg_pkg::ST_DIFF;
              end else begin
                neg_nxt   = pos_r[CW-1];
                mag_nxt   = MW'(pos_abs);
                state_nxt = qeg_pkg::ST_PREP;
              end
            end
            default: ;
          endcase
        end
      end
      qeg_pkg::ST_PREP: begin
        num_nxt   = cfg.steps_per_rev * cfg.thread_pitch_milli;
        den_nxt   = cfg.divisions_per_rev * cfg.screw_pitch_milli;
        prod_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = qeg_pkg::ST_CHECK;
      end
      qeg_pkg::ST_CHECK: begin
        if (den_r == '0) begin
          target_nxt = steps_r;
          state_nxt  = qeg_pkg::ST_DIFF;
        end else begin
          state_nxt = qeg_pkg::ST_MUL;
        end
      end
      qeg_pkg::ST_MUL: begin
        // top limb first
        pp_nxt    = mag_r[MW-1 -: 32] * num_r;
        mag_nxt   = mag_r << 32;
        state_nxt = qeg_pkg::ST_ACC;
      end
      qeg_pkg::ST_ACC: begin
        prod_nxt = (prod_r << 32) + PW'(pp_r);
        if (cnt_r == SW'(qeg_pkg::NLIMB - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = qeg_pkg::ST_DIV;
        end else begin
          cnt_nxt   = cnt_r + SW'(1);
          state_nxt = qeg_pkg::ST_MUL;
        end
      end
      qeg_pkg::ST_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_nxt  = trial_ge ? trial_sub[31:0] : trial[31:0];
        prod_nxt = {prod_r[PW-2:0], trial_ge};
        if (cnt_r == SW'(PW - 1)) begin
          state_nxt = qeg_pkg::ST_SAT;
        end else begin
          cnt_nxt = cnt_r + SW'(1);
        end
      end
      qeg_pkg::ST_SAT: begin
        target_nxt = neg_r ? (~qmag[CW-1:0] + CW'(1)) : qmag[CW-1:0];
        state_nxt  = qeg_pkg::ST_DIFF;
      end
      qeg_pkg::ST_DIFF: begin
        diff_nxt  = {target_r[CW-1], target_r} - {steps_r[CW-1], steps_r};
        steps_nxt = target_r;
        state_nxt = qeg_pkg::ST_EMIT;
      end
      qeg_pkg::ST_EMIT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = (diff_abs[CW:16] != '0) ? 16'hFFFF : diff_abs[15:0];
          out_dir_nxt   = ((delta_pos && !cfg.reverse_thread) ||
                           (delta_neg && cfg.reverse_thread)) ? 1'b0 : 1'b1;
          state_nxt     = qeg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qeg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qeg_pkg::ST_IDLE;
      pos_r       <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    pp_r        <= pp_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    target_r    <= target_nxt;
    diff_r      <= diff_nxt;
    out_count_r <= out_count_nxt;
    out_dir_r   <= out_dir_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_step_count = out_count_r;
  assign out_direction  = out_dir_r;

endmodule

`default_nettype wire

@@ rtl/quadrature_electronic_gearbox.sv @@
// Top level of the quadrature electronic gearbox: configuration registers,
// front end, command queue and back end. Depends on qeg_pkg and its submodules.
//
// Input: an item transfers on a clock edge with in_push high and in_full low.
//   in_kind selects an encoder edge, a step update or a counter clear; the
//   unused kind is taken and dropped.
// Result: while out_empty is low, out_step_count and out_direction hold the
//   oldest result; it transfers on an edge with out_pop high. Only step
//   updates produce a result.
// Config: cfg_we writes cfg_wdata into register cfg_index; write only while idle.
// Timing: a four-entry command queue decouples intake from execution. Edges
//   and clears retire in the back end's idle state as they are popped. An
//   update runs a limb multiplier over 32-bit limbs and a restoring divider
//   with one quotient bit per cycle over PROD_W bits; at zero position it
//   skips both. The divider sets the update throughput.
// Reset (rst_n low, synchronous): counters, queue and result register clear;
//   the configuration returns to its default values.
// Stall: a waiting result stops the back end only once the next result is
//   ready; later items wait in the queue and intake stops once it is full.
`default_nettype none

module quadrature_electronic_gearbox (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic [1:0]                        in_kind,
  input  wire logic                              in_channel,
  input  wire logic                              in_rising,
  input  wire logic                              in_other_level,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic [15:0]                            out_step_count,
  output logic                                   out_direction,
  input  wire logic                              cfg_we,
  input  wire logic [qeg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [qeg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  qeg_pkg::cfg_t      cfg_r, cfg_nxt;
  qeg_pkg::q_status_t q_status;
  qeg_pkg::cmd_t      push_cmd;
  qeg_pkg::cmd_t      head_cmd;
  logic               q_push;
  logic               q_pop;

  // Register file; writes outside the list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        qeg_pkg::CFG_THREAD_PITCH: cfg_nxt.thread_pitch_milli = cfg_wdata;
        qeg_pkg::CFG_REVERSE:      cfg_nxt.reverse_thread     = cfg_wdata[0];
        qeg_pkg::CFG_STEPS_REV:    cfg_nxt.steps_per_rev      = cfg_wdata;
        qeg_pkg::CFG_DIV_REV:      cfg_nxt.divisions_per_rev  = cfg_wdata;
        qeg_pkg::CFG_SCREW_PITCH:  cfg_nxt.screw_pitch_milli  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thread_pitch_milli <= 16'd750;
      cfg_r.reverse_thread     <= 1'b0;
      cfg_r.steps_per_rev      <= 16'd1600;
      cfg_r.divisions_per_rev  <= 16'd2400;
      cfg_r.screw_pitch_milli  <= 16'd2000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  qeg_front u_front (
    .in_push        (in_push),
    .in_kind        (in_kind),
    .in_channel     (in_channel),
    .in_rising      (in_rising),
    .in_other_level (in_other_level),
    .in_full        (in_full),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  qeg_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  qeg_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_cmd          (head_cmd),
    .q_status       (q_status),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_step_count (out_step_count),
    .out_direction  (out_direction)
  );

endmodule

`default_nettype wire

@@ rtl/qeg_checker.sv @@
// Port-level checks for the quadrature electronic gearbox, bound to the top.
// Depends on quadrature_electronic_gearbox.
`default_nettype none

module qeg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [15:0] out_step_count,
  input wire logic        out_direction
);

  // Reset leaves no result and room for input.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("reset did not clear result/queue");

  // A zero step delta always reports the backward code.
  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_step_count == 16'd0) |-> out_direction)
    else $error("zero delta with forward direction");

  // A waiting result is not withdrawn.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result dropped without transfer");

  // A stalled result keeps its payload.
  a_payload_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> ($stable(out_step_count) && $stable(out_direction)))
    else $error("stalled result changed");

endmodule

bind quadrature_electronic_gearbox qeg_checker u_qeg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_step_count (out_step_count),
  .out_direction  (out_direction)
);

`default_nettype wire
